// ----- hw/rtl/rsrb_pkg.sv -----
package rsrb_pkg;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [1:0] CSR_MIN_WINDOW  = 2'd1;
   localparam logic [1:0] CSR_MAX_WINDOW  = 2'd2;

   // Register reset values
   localparam logic [31:0] SAMPLE_RATE_RESET = 32'd90000;
   localparam logic [4:0]  MIN_WINDOW_RESET  = 5'd4;
   localparam logic [5:0]  MAX_WINDOW_RESET  = 6'd32;

   // Just under half of the 16-bit sequence space
   localparam logic [15:0] HALF_RANGE    = 16'h7FFF;
   localparam logic [1:0]  HDR_VERSION   = 2'd2;
   localparam logic [15:0] MIN_PKT_BYTES = 16'd12;

   typedef struct packed {
      logic [15:0] seq;
      logic [31:0] ssrc;
      logic [15:0] handle;
      logic [1:0]  track_type;
      logic [1:0]  version;
      logic [15:0] length;
      logic        payload_ok;
   } req_type;

   typedef struct packed {
      logic [15:0] out_seq;
      logic [15:0] out_handle;
      logic [1:0]  out_track_type;
      logic        last;
      logic [5:0]  occupancy;
      logic [31:0] wrap_count;
   } rsp_type;

   // One stored packet
   typedef struct packed {
      logic [1:0]  track_type;
      logic [15:0] handle;
      logic [15:0] seq;
   } entry_type;

   // Release request from the sequencer to the output buffer
   typedef struct packed {
      logic        push;
      logic        finish;
      entry_type   entry;
      logic [5:0]  occupancy;
      logic [31:0] wrap_count;
   } emit_ctl_type;

   typedef struct packed {
      logic room;
      logic pend;
   } emit_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FILTER,
      ST_SCAN,
      ST_DISPATCH,
      ST_EMIT,
      ST_WINDOW,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_FLUSH,
      OP_INSERT,
      OP_DRAIN,
      OP_WRAP,
      OP_WRAP_LAST,
      OP_FORCE
   } op_type;

endpackage

// ----- hw/rtl/rtp_sequence_reorder_buffer_top.sv -----
// A stored packet holds req_stall through check, filter and two store scans, each followed by
// a dispatch step, and the finish step. Each release adds an emit step, another store scan
// and its dispatch step; a drain or forced step adds a window step.
// One packet is taken at a time (req_stall stays high until the sequencer is idle); a release
// leaves rsp in the cycle after the next release or the finish step; rsp_stall stretches it.
// Reset (synchronous, active high) clears all valid bits at once: no clearing pass.
module rtp_sequence_reorder_buffer_top #(
   parameter int STORE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsrb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsrb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W = ((CNT_W > 5) ? CNT_W : 5) + 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

   // Configuration registers
   logic [31:0] rate_ff;
   logic [4:0]  min_ff;
   logic [5:0]  max_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= rsrb_pkg::SAMPLE_RATE_RESET;
         min_ff  <= rsrb_pkg::MIN_WINDOW_RESET;
         max_ff  <= rsrb_pkg::MAX_WINDOW_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rsrb_pkg::CSR_SAMPLE_RATE: rate_ff <= csr_data;
            rsrb_pkg::CSR_MIN_WINDOW:  min_ff  <= csr_data[4:0];
            rsrb_pkg::CSR_MAX_WINDOW:  max_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Sequencer and stream state
   rsrb_pkg::state_type state_ff, state_in;
   rsrb_pkg::op_type    op_ff, op_in;
   rsrb_pkg::req_type   item_ff, item_in;
   logic [15:0]         nes_ff, nes_in;
   logic [31:0]         ssrc_ff, ssrc_in;
   logic [31:0]         wrap_ff, wrap_in;
   logic [5:0]          win_ff, win_in;
   logic [STORE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic                drained_ff, drained_in;

   // Scan state
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   rsrb_pkg::entry_type best_ff, best_in;
   logic                floor_any_ff, floor_any_in;
   logic [15:0]         floor_ff, floor_in;
   logic                dup_ff, dup_in;
   logic                slot_found_ff, slot_found_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;

   // Memory and output buffer hookup
   logic                ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [$bits(rsrb_pkg::entry_type)-1:0] ram_rd_data;
   rsrb_pkg::entry_type ram_wr_data, rd_entry;
   rsrb_pkg::emit_ctl_type  ectl;
   rsrb_pkg::emit_stat_type estat;

   rsrb_ram #(
      .WIDTH($bits(rsrb_pkg::entry_type)),
      .DEPTH(STORE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(slot_ff),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   rsrb_out_buf u_out (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ectl),
      .stat     (estat),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   assign req_stall   = (state_ff != rsrb_pkg::ST_IDLE);
   assign rd_entry    = rsrb_pkg::entry_type'(ram_rd_data);
   assign ram_rd_addr = addr_ff[IDX_W-1:0];
   assign ram_rd_en   = (state_ff == rsrb_pkg::ST_SCAN) && (addr_ff < DEPTH_C);

   // Shared decisions
   logic reject, restart, late_drop, far_drop, scan_done;
   logic drain_hit, k_ahead, k_far, occ_gt_win, occ_lt_2min;
   logic [SUM_W-1:0] win_sum;
   logic [15:0] best_key;

   assign best_key  = best_ff.seq;
   assign reject    = (item_ff.length < rsrb_pkg::MIN_PKT_BYTES) || (rate_ff == 32'd0) ||
                      (item_ff.version != rsrb_pkg::HDR_VERSION) || !item_ff.payload_ok;
   assign restart   = (item_ff.ssrc != ssrc_ff) || (item_ff.seq == 16'd0);
   assign late_drop = (item_ff.seq < nes_ff) &&
                      ({1'b0, nes_ff} < ({1'b0, item_ff.seq} + 17'(max_ff)));
   assign far_drop  = (item_ff.seq >= nes_ff) && (nes_ff != 16'd0) &&
                      ((item_ff.seq - nes_ff) > rsrb_pkg::HALF_RANGE);
   assign scan_done = (addr_ff == DEPTH_C) && !rd_vld_ff;
   assign drain_hit = found_ff && (best_key == nes_ff);
   assign k_ahead   = best_key >= nes_ff;
   assign k_far     = (nes_ff - best_key) > rsrb_pkg::HALF_RANGE;
   assign occ_gt_win  = SUM_W'(occ_ff) > SUM_W'(win_ff);
   assign occ_lt_2min = SUM_W'(occ_ff) < SUM_W'({min_ff, 1'b0});
   assign win_sum     = SUM_W'(min_ff) + SUM_W'(occ_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsrb_pkg::ST_IDLE:
            if (req_valid) state_in = rsrb_pkg::ST_CHECK;
         rsrb_pkg::ST_CHECK: begin
            if (reject) state_in = rsrb_pkg::ST_IDLE;
            else if (restart) state_in = rsrb_pkg::ST_SCAN;
            else state_in = rsrb_pkg::ST_FILTER;
         end
         rsrb_pkg::ST_FILTER:
            state_in = (late_drop || far_drop) ? rsrb_pkg::ST_FINISH : rsrb_pkg::ST_SCAN;
         rsrb_pkg::ST_SCAN:
            if (scan_done) state_in = rsrb_pkg::ST_DISPATCH;
         rsrb_pkg::ST_DISPATCH: begin
            case (op_ff)
               rsrb_pkg::OP_FLUSH:
                  state_in = found_ff ? rsrb_pkg::ST_EMIT : rsrb_pkg::ST_FILTER;
               rsrb_pkg::OP_INSERT:
                  state_in = rsrb_pkg::ST_SCAN;
               rsrb_pkg::OP_DRAIN: begin
                  if (drain_hit) state_in = rsrb_pkg::ST_EMIT;
                  else if (drained_ff) state_in = rsrb_pkg::ST_WINDOW;
                  else if (!occ_gt_win) state_in = rsrb_pkg::ST_FINISH;
                  else if (!found_ff) state_in = rsrb_pkg::ST_WINDOW;
                  else if (k_ahead) state_in = rsrb_pkg::ST_EMIT;
                  else if (k_far && !occ_lt_2min) state_in = rsrb_pkg::ST_SCAN;
                  else state_in = rsrb_pkg::ST_WINDOW;
               end
               rsrb_pkg::OP_WRAP:
                  state_in = found_ff ? rsrb_pkg::ST_EMIT : rsrb_pkg::ST_SCAN;
               rsrb_pkg::OP_WRAP_LAST:
                  state_in = found_ff ? rsrb_pkg::ST_EMIT : rsrb_pkg::ST_WINDOW;
               default:
                  state_in = rsrb_pkg::ST_FINISH;
            endcase
         end
         rsrb_pkg::ST_EMIT: begin
            if (estat.room) begin
               if (op_ff inside {rsrb_pkg::OP_FLUSH, rsrb_pkg::OP_DRAIN, rsrb_pkg::OP_WRAP})
                  state_in = rsrb_pkg::ST_SCAN;
               else
                  state_in = rsrb_pkg::ST_WINDOW;
            end
         end
         rsrb_pkg::ST_WINDOW:
            state_in = rsrb_pkg::ST_FINISH;
         rsrb_pkg::ST_FINISH:
            if (estat.room) state_in = rsrb_pkg::ST_IDLE;
         default:
            state_in = rsrb_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      logic start;
      start         = 1'b0;
      op_in         = op_ff;
      item_in       = item_ff;
      nes_in        = nes_ff;
      ssrc_in       = ssrc_ff;
      wrap_in       = wrap_ff;
      win_in        = win_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      drained_in    = drained_ff;
      addr_in       = addr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      floor_any_in  = floor_any_ff;
      floor_in      = floor_ff;
      dup_in        = dup_ff;
      slot_found_in = slot_found_ff;
      slot_in       = slot_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data.seq        = item_ff.seq;
      ram_wr_data.handle     = item_ff.handle;
      ram_wr_data.track_type = item_ff.track_type;
      ectl.push       = 1'b0;
      ectl.finish     = 1'b0;
      ectl.entry      = best_ff;
      ectl.occupancy  = 6'(occ_ff - CNT_W'(1));
      ectl.wrap_count = wrap_ff;

      case (state_ff)
         rsrb_pkg::ST_IDLE:
            if (req_valid) item_in = req_data;
         rsrb_pkg::ST_CHECK: begin
            if (!reject && restart) begin
               ssrc_in = item_ff.ssrc;
               op_in   = rsrb_pkg::OP_FLUSH;
               start   = 1'b1;
            end
         end
         rsrb_pkg::ST_FILTER: begin
            if (!late_drop && !far_drop) begin
               op_in = rsrb_pkg::OP_INSERT;
               start = 1'b1;
            end
         end
         rsrb_pkg::ST_SCAN: begin
            // Issue one read a cycle, evaluate the entry in the following cycle
            if (addr_ff < DEPTH_C) begin
               addr_in   = addr_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = addr_ff[IDX_W-1:0];
            end
            if (rd_vld_ff) begin
               if (valid_ff[rd_idx_ff]) begin
                  if ((floor_any_ff || rd_entry.seq > floor_ff) &&
                      (!found_ff || rd_entry.seq < best_ff.seq)) begin
                     found_in    = 1'b1;
                     best_idx_in = rd_idx_ff;
                     best_in     = rd_entry;
                  end
                  if (rd_entry.seq == item_ff.seq) dup_in = 1'b1;
               end else if (!slot_found_ff) begin
                  slot_found_in = 1'b1;
                  slot_in       = rd_idx_ff;
               end
            end
         end
         rsrb_pkg::ST_DISPATCH: begin
            case (op_ff)
               rsrb_pkg::OP_FLUSH: begin
                  // Store empty: restart the stream
                  if (!found_ff) begin
                     wrap_in = 32'd0;
                     win_in  = {1'b0, min_ff};
                     nes_in  = item_ff.seq;
                  end
               end
               rsrb_pkg::OP_INSERT: begin
                  if (!dup_ff && slot_found_ff) begin
                     ram_wr_en         = 1'b1;
                     valid_in[slot_ff] = 1'b1;
                     occ_in            = occ_ff + CNT_W'(1);
                  end
                  op_in      = rsrb_pkg::OP_DRAIN;
                  drained_in = 1'b0;
                  start      = 1'b1;
               end
               rsrb_pkg::OP_DRAIN: begin
                  // Window exceeded with no in-order entry: force a release, start a wrap scan or drop a late entry
                  if (!drain_hit && !drained_ff && occ_gt_win && found_ff) begin
                     if (k_ahead) begin
                        op_in = rsrb_pkg::OP_FORCE;
                     end else if (k_far) begin
                        if (!occ_lt_2min) begin
                           wrap_in  = wrap_ff + 32'd1;
                           floor_in = nes_ff - 16'(occ_ff);
                           op_in    = rsrb_pkg::OP_WRAP;
                           start    = 1'b1;
                        end
                     end else begin
                        valid_in[best_idx_ff] = 1'b0;
                        occ_in                = occ_ff - CNT_W'(1);
                     end
                  end
               end
               rsrb_pkg::OP_WRAP: begin
                  if (!found_ff) begin
                     op_in = rsrb_pkg::OP_WRAP_LAST;
                     start = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         rsrb_pkg::ST_EMIT: begin
            if (estat.room) begin
               ectl.push             = 1'b1;
               valid_in[best_idx_ff] = 1'b0;
               occ_in                = occ_ff - CNT_W'(1);
               if (op_ff != rsrb_pkg::OP_WRAP) nes_in = best_key + 16'd1;
               if (op_ff == rsrb_pkg::OP_DRAIN) drained_in = 1'b1;
               if (op_ff inside {rsrb_pkg::OP_FLUSH, rsrb_pkg::OP_DRAIN, rsrb_pkg::OP_WRAP})
                  start = 1'b1;
            end
         end
         rsrb_pkg::ST_WINDOW:
            win_in = (win_sum > SUM_W'(max_ff)) ? max_ff : win_sum[5:0];
         rsrb_pkg::ST_FINISH:
            ectl.finish = estat.room;
         default: ;
      endcase

      // Restart the store scan
      if (start) begin
         addr_in       = '0;
         rd_vld_in     = 1'b0;
         found_in      = 1'b0;
         dup_in        = 1'b0;
         slot_found_in = 1'b0;
         floor_any_in  = (op_in != rsrb_pkg::OP_WRAP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rsrb_pkg::ST_IDLE;
         op_ff      <= rsrb_pkg::OP_FLUSH;
         nes_ff     <= 16'd0;
         ssrc_ff    <= 32'd0;
         wrap_ff    <= 32'd0;
         win_ff     <= {1'b0, rsrb_pkg::MIN_WINDOW_RESET};
         valid_ff   <= '0;
         occ_ff     <= '0;
         drained_ff <= 1'b0;
         addr_ff    <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         nes_ff     <= nes_in;
         ssrc_ff    <= ssrc_in;
         wrap_ff    <= wrap_in;
         win_ff     <= win_in;
         valid_ff   <= valid_in;
         occ_ff     <= occ_in;
         drained_ff <= drained_in;
         addr_ff    <= addr_in;
         rd_vld_ff  <= rd_vld_in;
      end
      item_ff       <= item_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      floor_any_ff  <= floor_any_in;
      floor_ff      <= floor_in;
      dup_ff        <= dup_in;
      slot_found_ff <= slot_found_in;
      slot_ff       <= slot_in;
   end

   // Fill count tracks the valid bits
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      occ_ff == CNT_W'($countones(valid_ff)))
      else $error("occupancy count out of step with valid bits");

   // No release is left pending once a transaction is done
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsrb_pkg::ST_IDLE) |-> !estat.pend)
      else $error("release pending while idle");

   // Insert only into a free entry
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !valid_ff[slot_ff])
      else $error("insert overwrites a held entry");

endmodule

// ----- hw/rtl/rsrb_ram.sv -----
module rsrb_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/rsrb_out_buf.sv -----
module rsrb_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  rsrb_pkg::emit_ctl_type ctl,
   output rsrb_pkg::emit_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsrb_pkg::rsp_type     rsp_data
);

   // Pending release waits here until we know whether it is the last one
   logic              pend_valid_ff, pend_valid_in;
   rsrb_pkg::rsp_type pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   rsrb_pkg::rsp_type out_ff, out_in;
   logic              out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign stat.room = !pend_valid_ff || out_free;
   assign stat.pend = pend_valid_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      // Move pending to the output; mark last on finish
      if ((ctl.push || ctl.finish) && pend_valid_ff) begin
         out_valid_in = 1'b1;
         out_in       = pend_ff;
         out_in.last  = ctl.finish;
      end
      if (ctl.push) begin
         pend_valid_in          = 1'b1;
         pend_in.out_seq        = ctl.entry.seq;
         pend_in.out_handle     = ctl.entry.handle;
         pend_in.out_track_type = ctl.entry.track_type;
         pend_in.last           = 1'b0;
         pend_in.occupancy      = ctl.occupancy;
         pend_in.wrap_count     = ctl.wrap_count;
      end else if (ctl.finish) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
